>>> rtl/lcvfe_pkg.sv
// ----------------------------------------------------------------------------
// lcvfe_pkg
// Shared codes, register map and types for the LED cube voxel frame engine.
// ----------------------------------------------------------------------------
package lcvfe_pkg;

  // Command codes
  localparam logic [3:0] CMD_FILL       = 4'd0;
  localparam logic [3:0] CMD_CLEAR      = 4'd1;
  localparam logic [3:0] CMD_LAYER_ON   = 4'd2;
  localparam logic [3:0] CMD_LAYER_OFF  = 4'd3;
  localparam logic [3:0] CMD_SIDE_ON    = 4'd4;
  localparam logic [3:0] CMD_SIDE_OFF   = 4'd5;
  localparam logic [3:0] CMD_SHIFT_DOWN = 4'd6;
  localparam logic [3:0] CMD_SHIFT_UP   = 4'd7;
  localparam logic [3:0] CMD_SHIFT_BACK = 4'd8;
  localparam logic [3:0] CMD_SHIFT_FWD  = 4'd9;
  localparam logic [3:0] CMD_SHIFT_LEFT = 4'd10;
  localparam logic [3:0] CMD_SHIFT_RGHT = 4'd11;
  localparam logic [3:0] CMD_COMMIT     = 4'd12;
  localparam logic [3:0] CMD_VOXEL      = 4'd13;
  localparam logic [3:0] CMD_BAR        = 4'd14;
  localparam logic [3:0] CMD_SCAN       = 4'd15;

  // Register word index (byte address bit 2)
  localparam logic REG_BAR_BASE = 1'b0;
  localparam logic REG_BAR_STEP = 1'b1;

  localparam logic [9:0] BAR_BASE_RST = 10'd500;
  localparam logic [6:0] BAR_STEP_RST = 7'd50;

  // Highest audio level
  localparam int LEVEL_MAX = 8;

  // One edit request toward the voxel store
  typedef struct packed {
    logic [3:0] command;
    logic [2:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic       value;
    logic [3:0] level;
  } lcvfe_edit_t;

endpackage

>>> rtl/lcvfe_bar_level.sv
// ----------------------------------------------------------------------------
// lcvfe_bar_level
// Audio sample to bar level 0..8, using compares against step multiples.
// ----------------------------------------------------------------------------
module lcvfe_bar_level import lcvfe_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [9:0]             bar_base,
  input  logic [6:0]             bar_step,
  output logic [3:0]             level
);

  localparam int DW = ((SAMPLE_BITS > 10) ? SAMPLE_BITS : 10) + 1;

  logic [DW-1:0] smp_ext;
  logic [DW-1:0] base_ext;
  logic [DW-1:0] diff;
  logic [3:0]    hits;

  assign smp_ext  = DW'(sample);
  assign base_ext = DW'(bar_base);
  assign diff     = smp_ext - base_ext;

  // floor(diff/step) >= m  <=>  diff >= m*step; a zero step passes every compare
  always_comb begin
    hits = 4'd0;
    for (int m = 1; m < LEVEL_MAX; m++) begin
      if (diff >= DW'(10'(m) * 10'(bar_step))) begin
        hits = hits + 4'd1;
      end
    end
  end

  assign level = (smp_ext > base_ext) ? (hits + 4'd1) : 4'd0;

endmodule

>>> rtl/lcvfe_voxel_store.sv
// ----------------------------------------------------------------------------
// lcvfe_voxel_store
// Working and display voxel buffers in flip-flops, edited one request a cycle,
// with a column read port for the scan.
// ----------------------------------------------------------------------------
module lcvfe_voxel_store import lcvfe_pkg::*; #(
  parameter int CUBE_EDGE = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         edit_en,
  input  lcvfe_edit_t                  edit,
  input  logic [$clog2(CUBE_EDGE)-1:0] scan_col,
  input  logic [$clog2(CUBE_EDGE)-1:0] scan_lay,
  output logic [7:0]                   scan_bits
);

  localparam int N        = CUBE_EDGE;
  localparam int OUT_BITS = (N < 8) ? N : 8;

  // [x][y][z]
  logic [N-1:0][N-1:0][N-1:0] work;
  logic [N-1:0][N-1:0][N-1:0] work_next;
  logic [N-1:0][N-1:0][N-1:0] display;
  logic [N-1:0][N-1:0][N-1:0] display_next;

  always_comb begin
    work_next    = work;
    display_next = display;
    case (edit.command)
      CMD_FILL:  display_next = '1;
      CMD_CLEAR: display_next = '0;
      CMD_LAYER_ON, CMD_LAYER_OFF: begin
        for (int x = 0; x < N; x++) begin
          for (int y = 0; y < N; y++) begin
            for (int z = 0; z < N; z++) begin
              if (int'(edit.z) == z) begin
                work_next[x][y][z] = (edit.command == CMD_LAYER_ON);
              end
            end
          end
        end
      end
      CMD_SIDE_ON, CMD_SIDE_OFF: begin
        for (int x = 0; x < N; x++) begin
          if (int'(edit.x) == x) begin
            work_next[x] = (edit.command == CMD_SIDE_ON) ? '1 : '0;
          end
        end
      end
      CMD_SHIFT_DOWN: begin
        for (int x = 0; x < N; x++) begin
          for (int y = 0; y < N; y++) begin
            work_next[x][y] = work[x][y] >> 1;
          end
        end
      end
      CMD_SHIFT_UP: begin
        for (int x = 0; x < N; x++) begin
          for (int y = 0; y < N; y++) begin
            work_next[x][y] = work[x][y] << 1;
          end
        end
      end
      CMD_SHIFT_BACK: begin
        for (int x = 0; x < N; x++) begin
          work_next[x] = work[x] >> N;
        end
      end
      CMD_SHIFT_FWD: begin
        for (int x = 0; x < N; x++) begin
          work_next[x] = work[x] << N;
        end
      end
      CMD_SHIFT_LEFT: work_next = work >> (N * N);
      CMD_SHIFT_RGHT: work_next = work << (N * N);
      CMD_COMMIT:     display_next = work;
      CMD_VOXEL: begin
        for (int x = 0; x < N; x++) begin
          for (int y = 0; y < N; y++) begin
            for (int z = 0; z < N; z++) begin
              if (int'(edit.x) == x && int'(edit.y) == y && int'(edit.z) == z) begin
                work_next[x][y][z] = edit.value;
              end
            end
          end
        end
      end
      CMD_BAR: begin
        // column (x, top y): level zero drops the bottom voxel, else light z < level
        for (int x = 0; x < N; x++) begin
          for (int z = 0; z < N; z++) begin
            if (int'(edit.x) == x) begin
              if (edit.level == 4'd0 && z == 0) begin
                work_next[x][N-1][z] = 1'b0;
              end else if (z < int'(edit.level)) begin
                work_next[x][N-1][z] = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work    <= '0;
      display <= '0;
    end else if (edit_en) begin
      work    <= work_next;
      display <= display_next;
    end
  end

  always_comb begin
    scan_bits = 8'd0;
    for (int i = 0; i < OUT_BITS; i++) begin
      scan_bits[i] = display[i][scan_col][scan_lay];
    end
  end

endmodule

>>> rtl/led_cube_voxel_frame_engine.sv
// ----------------------------------------------------------------------------
// led_cube_voxel_frame_engine
// Voxel frame engine for an LED cube: working and display buffers, plane and
// shift edits, audio bar, commit, and a column-by-column layer scan.
// ----------------------------------------------------------------------------
//
//  channel   signals                              direction  purpose
//  cmd       cmd_valid/cmd_ready + command fields in         one request per item
//  result    result_valid/result_ready + fields   out        one result per request
//  apb       psel/penable/pwrite/paddr/pwdata     in/out     bar_base, bar_step
//
//  Cycles: a request is taken on a cmd_valid/cmd_ready handshake; its result
//  is registered and shows on the next cycle. With result_ready high the rate
//  is one request per clock, set by the single result register at the output.
//  Stalls: cmd_ready drops only while a result waits and result_ready is low.
//  Reset: rst (sync, active high) clears both voxel buffers, the scan position,
//  the result valid flag and loads bar_base=500, bar_step=50.
//
module led_cube_voxel_frame_engine import lcvfe_pkg::*; #(
  parameter int CUBE_EDGE   = 8,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  logic [3:0]             command,
  input  logic [2:0]             coord_x,
  input  logic [2:0]             coord_y,
  input  logic [2:0]             coord_z,
  input  logic                   voxel_value,
  input  logic [SAMPLE_BITS-1:0] sample,
  // result channel
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [7:0]             column_data,
  output logic [2:0]             column_index,
  output logic [2:0]             layer_index,
  output logic                   column_load,
  output logic                   layer_show,
  output logic [3:0]             bar_level,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CW = $clog2(CUBE_EDGE);

  // ---------------------------------------------------------------- config
  logic [9:0] bar_base;
  logic [6:0] bar_step;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_base <= BAR_BASE_RST;
      bar_step <= BAR_STEP_RST;
    end else if (cfg_wr) begin
      // word select on address bit 2; low bits ignored
      case (paddr[2])
        REG_BAR_BASE: bar_base <= pwdata[9:0];
        REG_BAR_STEP: bar_step <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BAR_BASE: prdata = 32'(bar_base);
      REG_BAR_STEP: prdata = 32'(bar_step);
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  logic take;

  // result register doubles as the skid: accept whenever it is free or draining
  assign cmd_ready = ~result_valid | result_ready;
  assign take      = cmd_valid & cmd_ready;

  // ---------------------------------------------------------------- audio level
  logic [3:0] level;

  lcvfe_bar_level #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_bar (
    .sample  (sample),
    .bar_base(bar_base),
    .bar_step(bar_step),
    .level   (level)
  );

  // ---------------------------------------------------------------- voxels
  lcvfe_edit_t   edit;
  logic [CW-1:0] scan_col;
  logic [CW-1:0] scan_lay;
  logic [7:0]    scan_bits;

  assign edit.command = command;
  assign edit.x       = coord_x;
  assign edit.y       = coord_y;
  assign edit.z       = coord_z;
  assign edit.value   = voxel_value;
  assign edit.level   = level;

  lcvfe_voxel_store #(
    .CUBE_EDGE(CUBE_EDGE)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .edit_en  (take),
    .edit     (edit),
    .scan_col (scan_col),
    .scan_lay (scan_lay),
    .scan_bits(scan_bits)
  );

  // ---------------------------------------------------------------- scan position
  logic last_col;

  assign last_col = (scan_col == CW'(CUBE_EDGE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_col <= '0;
      scan_lay <= '0;
    end else if (take && command == CMD_SCAN) begin
      if (last_col) begin
        scan_col <= '0;
        scan_lay <= (scan_lay == CW'(CUBE_EDGE - 1)) ? '0 : scan_lay + CW'(1);
      end else begin
        scan_col <= scan_col + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- result register
  logic is_scan;
  logic is_bar;

  assign is_scan = (command == CMD_SCAN);
  assign is_bar  = (command == CMD_BAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // scan fields only on a scan tick, level only on a bar request
  always_ff @(posedge clk) begin
    if (take) begin
      column_data  <= is_scan ? scan_bits : 8'd0;
      column_index <= is_scan ? 3'(scan_col) : 3'd0;
      layer_index  <= is_scan ? 3'(scan_lay) : 3'd0;
      column_load  <= is_scan;
      layer_show   <= is_scan & last_col;
      bar_level    <= is_bar ? level : 4'd0;
    end
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LED cube voxel frame engine. A local model of
// both voxel buffers, the scan position and the bar registers predicts every
// result. A directed table comes first, then random requests under five
// register settings with varied back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb;
  import lcvfe_pkg::*;

  localparam int EDGE         = 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;   // long result stall, fills the block
  localparam int PHASE_ITEMS  = 335;
  localparam int DIR_ROWS     = 26;
  localparam int SHOW_MAX     = 10;    // mismatches printed in full

  // One request as it crosses the command channel
  typedef struct packed {
    logic [3:0] command;
    logic [2:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic       value;
    logic [9:0] sample;
  } cube_req_t;

  // One result as it leaves the block
  typedef struct packed {
    logic [7:0] column_data;
    logic [2:0] column_index;
    logic [2:0] layer_index;
    logic       column_load;
    logic       layer_show;
    logic [3:0] bar_level;
  } cube_out_t;

  // Directed row: request plus an optional hand-written result
  typedef struct packed {
    cube_req_t req;
    logic      typed;
    cube_out_t out;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;

  logic       cmd_valid   = 1'b0;
  logic       cmd_ready;
  logic [3:0] command     = '0;
  logic [2:0] coord_x     = '0;
  logic [2:0] coord_y     = '0;
  logic [2:0] coord_z     = '0;
  logic       voxel_value = 1'b0;
  logic [9:0] sample      = '0;

  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [7:0] column_data;
  logic [2:0] column_index;
  logic [2:0] layer_index;
  logic       column_load;
  logic       layer_show;
  logic [3:0] bar_level;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Local copy of the engine state. Voxel planes are indexed [y][z] with
  // bit x, so one entry of the display is exactly one scan column.
  logic [7:0] work_vox [EDGE][EDGE];
  logic [7:0] disp_vox [EDGE][EDGE];
  logic [2:0] scan_col;
  logic [2:0] scan_lay;
  logic [9:0] bar_base_q;
  logic [6:0] bar_step_q;

  cube_out_t cube_out_due [$];   // results owed by the block, oldest first
  int        fail_cnt     = 0;
  int        cycle_cnt    = 0;
  int        snd_idle_pct = 0;
  int        rcv_idle_pct = 0;
  bit        hold_start   = 1'b0;
  int        hold_left    = 0;

  dir_row_t  dir_tab [DIR_ROWS];

  led_cube_voxel_frame_engine u_top (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .command      (command),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .voxel_value  (voxel_value),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .column_data  (column_data),
    .column_index (column_index),
    .layer_index  (layer_index),
    .column_load  (column_load),
    .layer_show   (layer_show),
    .bar_level    (bar_level),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs on either channel
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Applies one request to the local state and returns the result it owes.
  function automatic cube_out_t apply_cube_cmd(cube_req_t r);
    cube_out_t  o;
    logic [7:0] nxt [EDGE][EDGE];
    int         lvl;
    o = '0;
    case (r.command)
      CMD_FILL: begin
        foreach (disp_vox[y, z]) disp_vox[y][z] = 8'hFF;
      end
      CMD_CLEAR: begin
        foreach (disp_vox[y, z]) disp_vox[y][z] = 8'h00;
      end
      CMD_LAYER_ON, CMD_LAYER_OFF: begin
        for (int y = 0; y < EDGE; y++)
          work_vox[y][r.z] = (r.command == CMD_LAYER_ON) ? 8'hFF : 8'h00;
      end
      CMD_SIDE_ON, CMD_SIDE_OFF: begin
        foreach (work_vox[y, z]) work_vox[y][z][r.x] = (r.command == CMD_SIDE_ON);
      end
      CMD_SHIFT_DOWN, CMD_SHIFT_UP, CMD_SHIFT_BACK,
      CMD_SHIFT_FWD, CMD_SHIFT_LEFT, CMD_SHIFT_RGHT: begin
        // zero fill at the edge the data moves away from
        for (int y = 0; y < EDGE; y++) begin
          for (int z = 0; z < EDGE; z++) begin
            case (r.command)
              CMD_SHIFT_DOWN: nxt[y][z] = (z < EDGE - 1) ? work_vox[y][z + 1] : 8'h00;
              CMD_SHIFT_UP:   nxt[y][z] = (z > 0) ? work_vox[y][z - 1] : 8'h00;
              CMD_SHIFT_BACK: nxt[y][z] = (y < EDGE - 1) ? work_vox[y + 1][z] : 8'h00;
              CMD_SHIFT_FWD:  nxt[y][z] = (y > 0) ? work_vox[y - 1][z] : 8'h00;
              CMD_SHIFT_LEFT: nxt[y][z] = work_vox[y][z] >> 1;
              default:        nxt[y][z] = work_vox[y][z] << 1;
            endcase
          end
        end
        work_vox = nxt;
      end
      CMD_COMMIT: begin
        disp_vox = work_vox;
      end
      CMD_VOXEL: begin
        work_vox[r.y][r.z][r.x] = r.value;
      end
      CMD_BAR: begin
        if (r.sample <= bar_base_q) lvl = 0;
        else if (bar_step_q == 0) lvl = LEVEL_MAX;
        else lvl = 1 + (int'(r.sample) - int'(bar_base_q)) / int'(bar_step_q);
        if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
        // bar lives in the back row; level zero only darkens its bottom voxel
        if (lvl == 0) work_vox[EDGE - 1][0][r.x] = 1'b0;
        for (int z = 0; z < lvl && z < EDGE; z++) work_vox[EDGE - 1][z][r.x] = 1'b1;
        o.bar_level = 4'(lvl);
      end
      default: begin
        // scan tick: emit column, strobe the layer on the last column
        o.column_data  = disp_vox[scan_col][scan_lay];
        o.column_index = scan_col;
        o.layer_index  = scan_lay;
        o.column_load  = 1'b1;
        o.layer_show   = (scan_col == 3'(EDGE - 1));
        if (scan_col == 3'(EDGE - 1)) begin
          scan_col = '0;
          scan_lay = scan_lay + 3'd1;
        end else begin
          scan_col = scan_col + 3'd1;
        end
      end
    endcase
    return o;
  endfunction

  // Random request. Scans are weighted up so display content is observed;
  // half the samples land near the bar base so every level shows up.
  function automatic cube_req_t rand_cube_req();
    cube_req_t r;
    int        hi;
    r.command = ($urandom_range(99) < 40) ? CMD_SCAN : 4'($urandom_range(14));
    r.x       = 3'($urandom_range(7));
    r.y       = 3'($urandom_range(7));
    r.z       = 3'($urandom_range(7));
    r.value   = 1'($urandom_range(1));
    if ($urandom_range(1) == 1) begin
      r.sample = 10'($urandom_range(1023));
    end else begin
      hi = int'(bar_base_q) + 9 * int'(bar_step_q) + 1;
      if (hi > 1023) hi = 1023;
      r.sample = 10'($urandom_range(hi, bar_base_q));
    end
    return r;
  endfunction

  // Offers one request, with random idle cycles ahead of it. The result owed
  // is queued at the accepting edge; a typed row overrides the prediction,
  // but the local state still moves.
  task automatic send_cube_req(input cube_req_t r, input bit typed, input cube_out_t want);
    cube_out_t o;
    while ($urandom_range(99) < snd_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid   <= 1'b1;
    command     <= r.command;
    coord_x     <= r.x;
    coord_y     <= r.y;
    coord_z     <= r.z;
    voxel_value <= r.value;
    sample      <= r.sample;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    o = apply_cube_cmd(r);
    cube_out_due.push_back(typed ? want : o);
  endtask

  // Waits until every owed result is back, then idles for the extra clocks asked for
  task automatic drain_results(input int extra);
    cmd_valid <= 1'b0;
    while (cube_out_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Register write, then a read back of the same word
  task automatic write_bar_reg(input logic reg_sel, input logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] mask;
    mask = (reg_sel == REG_BAR_BASE) ? 32'h3FF : 32'h7F;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if ((rd & mask) != val) begin
      fail_cnt++;
      if (fail_cnt <= SHOW_MAX)
        $display("readback mismatch reg %0d: exp %h got %h", reg_sel, val, rd & mask);
    end
    if (reg_sel == REG_BAR_BASE) bar_base_q = val[9:0];
    else bar_step_q = val[6:0];
  endtask

  // One random phase under one register setting and one idling mix
  task automatic run_bar_phase(input logic [9:0] base, input logic [6:0] step,
                               input int snd_pct, input int rcv_pct, input bit press);
    drain_results(2);
    write_bar_reg(REG_BAR_BASE, 32'(base));
    write_bar_reg(REG_BAR_STEP, 32'(step));
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    if (press) hold_start = 1'b1;
    repeat (PHASE_ITEMS) send_cube_req(rand_cube_req(), 1'b0, '0);
  endtask

  // Result side: checks each accepted result against the oldest one owed and
  // chooses ready for the next cycle. A long hold is counted down here.
  always @(posedge clk) begin
    cube_out_t got;
    cube_out_t want;
    if (!rst && result_valid && result_ready) begin
      got = '{column_data, column_index, layer_index, column_load, layer_show, bar_level};
      if (cube_out_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= SHOW_MAX) $display("result with nothing owed: %p", got);
      end else begin
        want = cube_out_due.pop_front();
        if (got.column_data  !== want.column_data  ||
            got.column_index !== want.column_index ||
            got.layer_index  !== want.layer_index  ||
            got.column_load  !== want.column_load  ||
            got.layer_show   !== want.layer_show   ||
            got.bar_level    !== want.bar_level) begin
          fail_cnt++;
          if (fail_cnt <= SHOW_MAX)
            $display("result mismatch: exp %p got %p", want, got);
        end
      end
    end
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    cube_out_t zero_out;
    zero_out = '0;

    // model state after reset
    foreach (work_vox[y, z]) begin
      work_vox[y][z] = 8'h00;
      disp_vox[y][z] = 8'h00;
    end
    scan_col   = '0;
    scan_lay   = '0;
    bar_base_q = BAR_BASE_RST;
    bar_step_q = BAR_STEP_RST;

    // Directed requests under the reset setting (base 500, step 50).
    // Typed results: scans right after reset and after fill/clear, edits
    // that return nothing, and bar levels at the sample extremes and at the
    // base, one past the base and the step boundaries.
    dir_tab = '{
      '{'{CMD_SCAN,       3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b1, '{8'h00, 3'd0, 3'd0, 1'b1, 1'b0, 4'd0}},
      '{'{CMD_FILL,       3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b1, zero_out},
      '{'{CMD_SCAN,       3'd7, 3'd7, 3'd7, 1'b1, 10'd1023}, 1'b1, '{8'hFF, 3'd1, 3'd0, 1'b1, 1'b0, 4'd0}},
      '{'{CMD_CLEAR,      3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b1, zero_out},
      '{'{CMD_SCAN,       3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b1, '{8'h00, 3'd2, 3'd0, 1'b1, 1'b0, 4'd0}},
      '{'{CMD_BAR,        3'd7, 3'd0, 3'd0, 1'b0, 10'd1023}, 1'b1, '{8'h00, 3'd0, 3'd0, 1'b0, 1'b0, 4'd8}},
      '{'{CMD_BAR,        3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b1, zero_out},
      '{'{CMD_BAR,        3'd3, 3'd0, 3'd0, 1'b0, 10'd500},  1'b1, zero_out},
      '{'{CMD_BAR,        3'd3, 3'd0, 3'd0, 1'b0, 10'd501},  1'b1, '{8'h00, 3'd0, 3'd0, 1'b0, 1'b0, 4'd1}},
      '{'{CMD_BAR,        3'd2, 3'd0, 3'd0, 1'b0, 10'd550},  1'b1, '{8'h00, 3'd0, 3'd0, 1'b0, 1'b0, 4'd2}},
      '{'{CMD_BAR,        3'd5, 3'd0, 3'd0, 1'b0, 10'd850},  1'b1, '{8'h00, 3'd0, 3'd0, 1'b0, 1'b0, 4'd8}},
      '{'{CMD_LAYER_ON,   3'd0, 3'd0, 3'd7, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_LAYER_OFF,  3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_SIDE_ON,    3'd7, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_SIDE_OFF,   3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_VOXEL,      3'd0, 3'd0, 3'd7, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_VOXEL,      3'd7, 3'd0, 3'd0, 1'b1, 10'd0},    1'b0, zero_out},
      '{'{CMD_SHIFT_DOWN, 3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_SHIFT_UP,   3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_SHIFT_BACK, 3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_SHIFT_FWD,  3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_SHIFT_LEFT, 3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_SHIFT_RGHT, 3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_COMMIT,     3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_SCAN,       3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out},
      '{'{CMD_SCAN,       3'd0, 3'd0, 3'd0, 1'b0, 10'd0},    1'b0, zero_out}
    };

    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_cube_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].out);

    // Sender sparse / receiver busy, then swapped, then full rate with one
    // long result stall so the command side backs up.
    run_bar_phase(10'd0,    7'd1,   37, 86, 1'b0);
    run_bar_phase(10'd1023, 7'd127, 37, 86, 1'b0);
    run_bar_phase(10'($urandom_range(1023)), 7'($urandom_range(127, 1)), 86, 37, 1'b0);
    // zero step: any sample above the base is full scale
    run_bar_phase(10'd600,  7'd0,   86, 37, 1'b0);
    run_bar_phase(10'($urandom_range(1023)), 7'd127, 0, 0, 1'b1);

    drain_results(4);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lcvfe_pkg.sv
rtl/lcvfe_bar_level.sv
rtl/lcvfe_voxel_store.sv
rtl/led_cube_voxel_frame_engine.sv
tb/tb.sv
